/* hw/rtl/scf_pkg.sv */
// ----------------------------------------------------------------------------
// Serial command framer package
// Character codes, byte classes and the command and status words that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package scf_pkg;

    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_END   = 8'h23;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_KEY_M = 8'h6D;
    localparam logic [7:0] CH_KEY_H = 8'h68;
    localparam logic [7:0] CH_KEY_P = 8'h70;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    typedef enum logic [2:0] {
        CLS_KEY,
        CLS_START,
        CLS_END,
        CLS_BS,
        CLS_OTHER
    } byte_cls_t;

    typedef enum logic [2:0] {
        SEL_START,
        SEL_KEY,
        SEL_COLON,
        SEL_MEM,
        SEL_EMPTY
    } out_sel_t;

    typedef struct packed {
        logic     accept;
        logic     rd_issue;
        logic     rd_next;
        logic     out_load;
        out_sel_t out_sel;
        logic     clear;
    } ctl_cmd_t;

    typedef struct packed {
        byte_cls_t cls;
        logic      frame_open;
        logic      edited_zero;
        logic      last_byte;
        logic      out_free;
    } dp_stat_t;

    function automatic byte_cls_t classify(input logic [7:0] c);
        byte_cls_t cls;
        if (c == CH_KEY_M || c == CH_KEY_H || c == CH_KEY_P ||
            c == CH_SLASH || c == CH_MINUS || c == CH_PLUS)
        begin
            cls = CLS_KEY;
        end
        else if (c == CH_START)
        begin
            cls = CLS_START;
        end
        else if (c == CH_END)
        begin
            cls = CLS_END;
        end
        else if (c == CH_BS)
        begin
            cls = CLS_BS;
        end
        else
        begin
            cls = CLS_OTHER;
        end
        return cls;
    endfunction

endpackage

/* hw/rtl/scf_rx_if.sv */
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel that carries one received serial byte per word.
// ----------------------------------------------------------------------------
interface scf_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

/* hw/rtl/scf_cmd_if.sv */
// ----------------------------------------------------------------------------
// Command byte channel
// Valid/ready channel that carries one command character per word.
// ----------------------------------------------------------------------------
interface scf_cmd_if;
    logic       valid;
    logic       ready;
    logic [7:0] cmd_byte;
    logic       cmd_last;
    logic       cmd_empty;

    modport source (output valid, output cmd_byte, output cmd_last, output cmd_empty,
                    input ready);
    modport sink (input valid, input cmd_byte, input cmd_last, input cmd_empty,
                  output ready);
endinterface

/* hw/rtl/serial_command_line_framer_top.sv */
// ----------------------------------------------------------------------------
// Serial command line framer
// Frames received serial bytes into commands and emits them word by word.
// ----------------------------------------------------------------------------
// An ordinary received byte is taken while the framer is idle. A single-key
// character holds the input while "$x:" is loaded into the output register
// word by word, longer if the sink stalls. A terminator holds the input while
// each stored character is read from the line store and then loaded into
// the output register, or while the empty word is loaded when the command
// was erased. The line store needs no clearing after reset, so the block
// takes bytes as soon as reset is released.
module serial_command_line_framer_top #(
    parameter int LINE_DEPTH = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    scf_rx_if.sink    rx,
    scf_cmd_if.source cmd
);

    scf_pkg::ctl_cmd_t ctl_cmd;
    scf_pkg::dp_stat_t dp_stat;
    logic              in_ready;

    assign rx.ready = in_ready;

    scf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (in_ready),
        .stat     (dp_stat),
        .cmd      (ctl_cmd)
    );

    scf_datapath #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_byte   (rx.rx_byte),
        .out_ready (cmd.ready),
        .cmd       (ctl_cmd),
        .stat      (dp_stat),
        .cmd_valid (cmd.valid),
        .cmd_byte  (cmd.cmd_byte),
        .cmd_last  (cmd.cmd_last),
        .cmd_empty (cmd.cmd_empty)
    );

endmodule

/* hw/rtl/scf_datapath.sv */
// ----------------------------------------------------------------------------
// Serial command framer datapath
// Line store, edit and raw counters, read pointer and output register.
// ----------------------------------------------------------------------------
module scf_datapath #(
    parameter int LINE_DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       rx_byte,
    input  logic             out_ready,
    input  scf_pkg::ctl_cmd_t cmd,
    output scf_pkg::dp_stat_t stat,
    output logic             cmd_valid,
    output logic [7:0]       cmd_byte,
    output logic             cmd_last,
    output logic             cmd_empty
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam logic [AW-1:0] RAW_MAX = AW'(LINE_DEPTH - 1);

    logic [7:0]    line_mem [LINE_DEPTH];
    logic [AW-1:0] raw_reg, raw_next;
    logic [AW-1:0] edited_reg, edited_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [7:0]    key_reg;
    logic [7:0]    rd_data_reg;
    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;
    logic          out_empty_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          frame_open;
    logic          last_byte;
    scf_pkg::byte_cls_t cls;

    assign cls        = scf_pkg::classify(rx_byte);
    assign frame_open = (raw_reg != '0);
    assign last_byte  = (rd_idx_reg == edited_reg - AW'(1));

    assign stat.cls         = cls;
    assign stat.frame_open  = frame_open;
    assign stat.edited_zero = (edited_reg == '0);
    assign stat.last_byte   = last_byte;
    assign stat.out_free    = !out_valid_reg || out_ready;

    always_comb
    begin
        raw_next    = raw_reg;
        edited_next = edited_reg;
        rd_idx_next = rd_idx_reg;
        wr_en       = 1'b0;
        wr_addr     = edited_reg;
        if (cmd.clear)
        begin
            raw_next    = '0;
            edited_next = '0;
            rd_idx_next = '0;
        end
        else if (cmd.rd_next)
        begin
            rd_idx_next = rd_idx_reg + AW'(1);
        end
        else if (cmd.accept)
        begin
            if (!frame_open)
            begin
                if (cls == scf_pkg::CLS_START)
                begin
                    wr_en       = 1'b1;
                    wr_addr     = '0;
                    edited_next = AW'(1);
                    raw_next    = AW'(1);
                end
            end
            else if (cls != scf_pkg::CLS_END)
            begin
                if (cls == scf_pkg::CLS_BS)
                begin
                    if (edited_reg != '0)
                    begin
                        edited_next = edited_reg - AW'(1);
                    end
                end
                else
                begin
                    wr_en       = 1'b1;
                    edited_next = edited_reg + AW'(1);
                end
                if (raw_reg == RAW_MAX)
                begin
                    raw_next    = '0;
                    edited_next = '0;
                end
                else
                begin
                    raw_next = raw_reg + AW'(1);
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg       <= '0;
            edited_reg    <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            raw_reg       <= raw_next;
            edited_reg    <= edited_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[wr_addr] <= rx_byte;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= line_mem[rd_idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && !frame_open && cls == scf_pkg::CLS_KEY)
        begin
            key_reg <= rx_byte;
        end
        if (cmd.out_load)
        begin
            unique case (cmd.out_sel)
                scf_pkg::SEL_START:
                begin
                    out_byte_reg  <= scf_pkg::CH_START;
                    out_last_reg  <= 1'b0;
                    out_empty_reg <= 1'b0;
                end
                scf_pkg::SEL_KEY:
                begin
                    out_byte_reg  <= key_reg;
                    out_last_reg  <= 1'b0;
                    out_empty_reg <= 1'b0;
                end
                scf_pkg::SEL_COLON:
                begin
                    out_byte_reg  <= scf_pkg::CH_COLON;
                    out_last_reg  <= 1'b1;
                    out_empty_reg <= 1'b0;
                end
                scf_pkg::SEL_MEM:
                begin
                    out_byte_reg  <= rd_data_reg;
                    out_last_reg  <= last_byte;
                    out_empty_reg <= 1'b0;
                end
                default:
                begin
                    out_byte_reg  <= 8'h00;
                    out_last_reg  <= 1'b1;
                    out_empty_reg <= 1'b1;
                end
            endcase
        end
    end

    assign cmd_valid = out_valid_reg;
    assign cmd_byte  = out_byte_reg;
    assign cmd_last  = out_last_reg;
    assign cmd_empty = out_empty_reg;

    // The edited length never runs ahead of the raw count in an open frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_open |-> (edited_reg <= raw_reg))
        else $error("edited length exceeds raw count");

    // Reads only touch bytes of the current command.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |-> (rd_idx_reg < edited_reg))
        else $error("line store read beyond edited length");

    // A new word never overwrites one that the sink has not taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten");

    // Closing a command leaves the framer idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (raw_reg == '0 && edited_reg == '0 && rd_idx_reg == '0))
        else $error("framer not idle after command end");

endmodule

/* hw/rtl/scf_ctrl.sv */
// ----------------------------------------------------------------------------
// Serial command framer controller
// Sequences byte intake and the emission of single-key and framed commands.
// ----------------------------------------------------------------------------
module scf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  scf_pkg::dp_stat_t stat,
    output scf_pkg::ctl_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY_S,
        ST_KEY_X,
        ST_KEY_C,
        ST_EMPTY,
        ST_RD,
        ST_WR
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.rd_issue = 1'b0;
        cmd.rd_next  = 1'b0;
        cmd.out_load = 1'b0;
        cmd.out_sel  = scf_pkg::SEL_MEM;
        cmd.clear    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    if (!stat.frame_open && stat.cls == scf_pkg::CLS_KEY)
                    begin
                        state_next = ST_KEY_S;
                    end
                    else if (stat.frame_open && stat.cls == scf_pkg::CLS_END)
                    begin
                        state_next = stat.edited_zero ? ST_EMPTY : ST_RD;
                    end
                end
            end
            ST_KEY_S:
            begin
                cmd.out_sel = scf_pkg::SEL_START;
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_KEY_X;
                end
            end
            ST_KEY_X:
            begin
                cmd.out_sel = scf_pkg::SEL_KEY;
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_KEY_C;
                end
            end
            ST_KEY_C:
            begin
                cmd.out_sel = scf_pkg::SEL_COLON;
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_EMPTY:
            begin
                cmd.out_sel = scf_pkg::SEL_EMPTY;
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_WR;
            end
            ST_WR:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (stat.last_byte)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                        state_next  = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A store read is always followed by the load of its word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |=> (state_reg == ST_WR))
        else $error("store read not followed by output stage");

    // A terminator with nothing stored gives exactly the empty word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && stat.frame_open && stat.cls == scf_pkg::CLS_END && stat.edited_zero)
        |=> (state_reg == ST_EMPTY))
        else $error("empty command not flagged");

    // Bytes are taken only between commands.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> (!cmd.out_load && !cmd.rd_issue && !cmd.clear))
        else $error("byte taken during command emission");

endmodule

/* tb/tb_serial_command_line_framer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial command line framer testbench
// Feeds received bytes into the framer and checks every emitted command word
// against a cycle-free prediction of the framing rules. Directed tests cover
// dropped bytes, single-key commands, framed commands, backspace editing, the
// longest command and overflow. A long output hold-off and a drain pause
// follow, then random frames, keys and noise with random idling on both
// channels.
// ----------------------------------------------------------------------------
module tb_serial_command_line_framer_top;

    localparam int LINE_DEPTH   = 64;
    localparam int RANDOM_ITEMS = 300;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 20;
    localparam int CYCLE_LIMIT  = 5000000;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       empty;
    } cmd_word_t;

    logic clk = 1'b0;
    logic rst_n;

    scf_rx_if  rx();
    scf_cmd_if cmd();

    serial_command_line_framer_top #(
        .LINE_DEPTH(LINE_DEPTH)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .rx   (rx),
        .cmd  (cmd)
    );

    cmd_word_t   cmd_word_q[$];
    logic [7:0]  line_mem[LINE_DEPTH];
    int unsigned line_len;
    int unsigned raw_len;
    int unsigned taken_cnt;
    int unsigned error_cnt;
    int unsigned cycle_cnt;
    bit          idle_on;
    bit          hold_req;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit is_key_char(input logic [7:0] c);
        return c inside {scf_pkg::CH_KEY_M, scf_pkg::CH_KEY_H, scf_pkg::CH_KEY_P,
                         scf_pkg::CH_SLASH, scf_pkg::CH_MINUS, scf_pkg::CH_PLUS};
    endfunction

    function automatic void push_word(input logic [7:0] c, input logic last,
                                      input logic empty);
        cmd_word_t w;
        w.ch    = c;
        w.last  = last;
        w.empty = empty;
        cmd_word_q.push_back(w);
    endfunction

    function automatic void predict_command(input logic [7:0] c);
        if (raw_len == 0)
        begin
            if (is_key_char(c))
            begin
                push_word(scf_pkg::CH_START, 1'b0, 1'b0);
                push_word(c, 1'b0, 1'b0);
                push_word(scf_pkg::CH_COLON, 1'b1, 1'b0);
            end
            else if (c == scf_pkg::CH_START)
            begin
                line_mem[0] = c;
                line_len    = 1;
                raw_len     = 1;
            end
        end
        else if (c == scf_pkg::CH_END)
        begin
            if (line_len == 0)
            begin
                push_word(8'h00, 1'b1, 1'b1);
            end
            else
            begin
                for (int unsigned i = 0; i < line_len; i++)
                begin
                    push_word(line_mem[i], i + 1 == line_len, 1'b0);
                end
            end
            raw_len  = 0;
            line_len = 0;
        end
        else
        begin
            if (c == scf_pkg::CH_BS)
            begin
                if (line_len > 0)
                begin
                    line_len--;
                end
            end
            else
            begin
                line_mem[line_len] = c;
                line_len++;
            end
            raw_len++;
            if (raw_len >= LINE_DEPTH)
            begin
                raw_len  = 0;
                line_len = 0;
            end
        end
    endfunction

    function automatic logic [7:0] body_char();
        logic [7:0] c;
        if ($urandom_range(0, 7) == 0)
        begin
            return scf_pkg::CH_BS;
        end
        do
        begin
            c = 8'($urandom_range(0, 255));
        end
        while (c == scf_pkg::CH_END);
        return c;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            rx.valid <= 1'b0;
            gap = $urandom_range(1, 18);
            repeat (gap) @(posedge clk);
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (!rx.ready);
        taken_cnt++;
        predict_command(b);
    endtask

    task automatic send_frame(input int unsigned body_len, input bit with_end);
        send_byte(scf_pkg::CH_START);
        for (int unsigned i = 0; i < body_len; i++)
        begin
            send_byte(body_char());
        end
        if (with_end)
        begin
            send_byte(scf_pkg::CH_END);
        end
    endtask

    task automatic drain_results();
        rx.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (cmd_word_q.size() != 0);
    endtask

    always
    begin : cmd_ready_gen
        int span;
        @(posedge clk);
        if (hold_req)
        begin
            cmd.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clk);
            hold_req = 1'b0;
        end
        else if (idle_on && $urandom_range(0, 2) == 0)
        begin
            cmd.ready <= 1'b0;
            span = $urandom_range(1, 18);
            repeat (span - 1) @(posedge clk);
        end
        else
        begin
            cmd.ready <= 1'b1;
            span = $urandom_range(1, 24);
            repeat (span - 1) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : cmd_check
        cmd_word_t want;
        if (rst_n && cmd.valid && cmd.ready)
        begin
            if (cmd_word_q.size() == 0)
            begin
                $error("cmd_byte unexpected: expected none, actual %02h", cmd.cmd_byte);
                error_cnt++;
            end
            else
            begin
                want = cmd_word_q.pop_front();
                if (cmd.cmd_empty !== want.empty)
                begin
                    $error("cmd_empty mismatch: expected %0b, actual %0b",
                           want.empty, cmd.cmd_empty);
                    error_cnt++;
                end
                if (!want.empty && cmd.cmd_byte !== want.ch)
                begin
                    $error("cmd_byte mismatch: expected %02h, actual %02h",
                           want.ch, cmd.cmd_byte);
                    error_cnt++;
                end
                if (cmd.cmd_last !== want.last)
                begin
                    $error("cmd_last mismatch: expected %0b, actual %0b",
                           want.last, cmd.cmd_last);
                    error_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tb_serial_command_line_framer_top: FAIL");
            $finish;
        end
    end

    task automatic test_idle_drop();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(scf_pkg::CH_END);
        send_byte(scf_pkg::CH_BS);
        send_byte(scf_pkg::CH_COLON);
        send_byte(8'h61);
    endtask

    task automatic test_single_keys();
        send_byte(scf_pkg::CH_KEY_M);
        send_byte(scf_pkg::CH_KEY_H);
        send_byte(scf_pkg::CH_KEY_P);
        send_byte(scf_pkg::CH_SLASH);
        send_byte(scf_pkg::CH_MINUS);
        send_byte(scf_pkg::CH_PLUS);
    endtask

    task automatic test_framed();
        send_byte(scf_pkg::CH_START);
        send_byte(8'h61);
        send_byte(8'h62);
        send_byte(scf_pkg::CH_END);
        send_byte(scf_pkg::CH_START);
        send_byte(scf_pkg::CH_START);
        send_byte(8'h00);
        send_byte(scf_pkg::CH_KEY_M);
        send_byte(8'hFF);
        send_byte(scf_pkg::CH_END);
    endtask

    task automatic test_backspace();
        send_byte(scf_pkg::CH_START);
        send_byte(scf_pkg::CH_BS);
        send_byte(scf_pkg::CH_BS);
        send_byte(scf_pkg::CH_END);
        send_byte(scf_pkg::CH_START);
        send_byte(8'h78);
        send_byte(scf_pkg::CH_BS);
        send_byte(8'h79);
        send_byte(scf_pkg::CH_END);
    endtask

    task automatic test_longest();
        send_frame(LINE_DEPTH - 2, 1'b1);
    endtask

    task automatic test_overflow();
        send_frame(LINE_DEPTH - 1, 1'b0);
        send_byte(scf_pkg::CH_KEY_H);
    endtask

    task automatic test_pressure();
        drain_results();
        hold_req = 1'b1;
        send_byte(scf_pkg::CH_KEY_P);
        send_byte(scf_pkg::CH_PLUS);
        send_byte(scf_pkg::CH_KEY_M);
        send_frame(20, 1'b1);
        send_byte(scf_pkg::CH_SLASH);
        drain_results();
    endtask

    task automatic random_scenario();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                send_frame($urandom_range(40, LINE_DEPTH - 2), 1'b1);
            end
            else
            begin
                send_frame($urandom_range(0, 12), 1'b1);
            end
        end
        else if (pick < 70)
        begin
            case ($urandom_range(0, 5))
                0: send_byte(scf_pkg::CH_KEY_M);
                1: send_byte(scf_pkg::CH_KEY_H);
                2: send_byte(scf_pkg::CH_KEY_P);
                3: send_byte(scf_pkg::CH_SLASH);
                4: send_byte(scf_pkg::CH_MINUS);
                default: send_byte(scf_pkg::CH_PLUS);
            endcase
        end
        else if (pick < 88)
        begin
            send_byte(8'($urandom_range(0, 255)));
        end
        else if (pick < 96)
        begin
            send_byte(scf_pkg::CH_START);
            repeat ($urandom_range(0, 4)) send_byte(scf_pkg::CH_BS);
            repeat ($urandom_range(0, 3)) send_byte(body_char());
            send_byte(scf_pkg::CH_END);
        end
        else
        begin
            send_frame(LINE_DEPTH - 1, 1'b0);
        end
    endtask

    task automatic test_random();
        int unsigned first;
        int unsigned chunk_end;
        first = taken_cnt;
        while (taken_cnt - first < RANDOM_ITEMS)
        begin
            if (taken_cnt - first >= RANDOM_ITEMS - 60)
            begin
                idle_on = 1'b0;
            end
            else
            begin
                idle_on = $urandom_range(0, 3) != 0;
            end
            chunk_end = taken_cnt + 40;
            while (taken_cnt < chunk_end && taken_cnt - first < RANDOM_ITEMS)
            begin
                random_scenario();
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        rx.valid   = 1'b0;
        rx.rx_byte = 8'h00;
        cmd.ready  = 1'b0;
        line_len   = 0;
        raw_len    = 0;
        taken_cnt  = 0;
        error_cnt  = 0;
        cycle_cnt  = 0;
        idle_on    = 1'b1;
        hold_req   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_drop();
        test_single_keys();
        test_framed();
        test_backspace();
        test_longest();
        test_overflow();
        test_pressure();
        test_random();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_cnt == 0 && cmd_word_q.size() == 0)
        begin
            $display("tb_serial_command_line_framer_top: PASS");
        end
        else
        begin
            $display("tb_serial_command_line_framer_top: FAIL");
        end
        $finish;
    end

endmodule
